// ===== rtl/kmm_pkg.sv =====
// ----------------------------------------------------------------------------
// kmm_pkg
// Shared types, constants and helpers of the rolling k-mer minimizer.
// ----------------------------------------------------------------------------
package kmm_pkg;

    localparam int MIN_W = 64;
    localparam int LEN_W = 6;

    localparam logic REG_KMER_SIZE = 1'b0;
    localparam logic REG_MIN_LEN   = 1'b1;

    localparam logic [LEN_W-1:0] KMER_RST = 6'd16;
    localparam logic [LEN_W-1:0] MLEN_RST = 6'd8;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    typedef struct packed {
        logic shift;
        logic scan_load;
        logic scan_shift;
    } t_cell_ctl;

    typedef struct packed {
        logic load;
        logic step;
    } t_trk_ctl;

    // low n bases set, all ones from 32 bases up
    function automatic logic [MIN_W-1:0] base_mask(input logic [LEN_W-1:0] n);
        logic [MIN_W-1:0] m;
        if (n >= 6'd32) begin
            m = '1;
        end else begin
            m = (64'd1 << {n, 1'b0}) - 64'd1;
        end
        return m;
    endfunction

endpackage

// ===== rtl/rolling_kmer_minimizer.sv =====
// ----------------------------------------------------------------------------
// rolling_kmer_minimizer
// Rolling minimizer over a k-mer window, one nucleotide per item.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_stall carries one base and a restart flag per item.
// Output channel o_valid/i_stall returns one result per item: the current
// minimizer, its remaining life and the window-full flag.
// Configuration writes (kmer_size, minimizer_len) use i_cfg_valid/o_cfg_ready,
// are always taken; the user must keep them to idle periods (not enforced).
// The window is a row of MAX_KMER base cells shifting by one per item. When
// the minimizer expires, a second row in the same cells shifts one base per
// cycle past a single 64-bit compare, so a rescan visits the k-m+1 windows
// one per cycle.
// Throughput: 1 item per cycle while no rescan is needed and no result is
// pending; an item that triggers a rescan holds the input until the rescan ends.
// The result enters the output register at the edge that accepts the item,
// or at the end of its rescan, when the output register is free.
// While the receiver stalls, one more item is taken and its result held
// internally; after that o_stall stays high until the output drains.
// Reset clears the window, the minimum, the fill count and sets life to 1,
// kmer_size to 16 and minimizer_len to 8.
// ----------------------------------------------------------------------------
module rolling_kmer_minimizer
    import kmm_pkg::*;
#(
    parameter int MAX_KMER = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_base,
    input  logic             i_restart,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [MIN_W-1:0] o_minimizer,
    output logic [LEN_W-1:0] o_life_left,
    output logic             o_window_full,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [LEN_W-1:0] i_cfg_data
);

    localparam int ROW_W = 2 * MAX_KMER;

    t_state           r_state;
    t_state           n_state;
    logic [LEN_W-1:0] r_k_cfg;
    logic [LEN_W-1:0] r_m_cfg;
    logic [MIN_W-1:0] r_min;
    logic [LEN_W-1:0] r_life;
    logic [LEN_W-1:0] r_fill;
    logic             r_pend;
    logic             r_ov;
    logic [MIN_W-1:0] r_omin;
    logic [LEN_W-1:0] r_olife;
    logic             r_ofull;

    logic [LEN_W-1:0] k_eff;
    logic [LEN_W-1:0] m_eff;
    logic [LEN_W-1:0] full_life;
    logic [MIN_W-1:0] mm;

    logic             accept;
    logic             out_free;
    logic [MIN_W-1:0] min_base;
    logic [LEN_W-1:0] life_base;
    logic [LEN_W-1:0] fill_base;
    logic [LEN_W-1:0] n_fill;
    logic [MIN_W-1:0] newest;
    logic             take_new;
    logic             go_scan;
    logic             scan_done;
    logic             fin;
    logic [MIN_W-1:0] fin_min;
    logic [LEN_W-1:0] fin_life;
    logic             fin_full;

    t_cell_ctl        cell_ctl;
    t_trk_ctl         trk_ctl;
    logic [MIN_W-1:0] trk_best;
    logic [LEN_W-1:0] trk_best_pos;
    logic [LEN_W-1:0] trk_pos;

    logic [1:0]       c_base [MAX_KMER];
    logic [1:0]       c_next [MAX_KMER];
    logic [1:0]       c_scan [MAX_KMER];
    logic [ROW_W-1:0] next_flat;
    logic [ROW_W-1:0] scan_flat;

    // effective sizes
    always_comb begin
        k_eff = r_k_cfg;
        if (r_k_cfg == '0) begin
            k_eff = 6'd1;
        end else if (r_k_cfg > LEN_W'(MAX_KMER)) begin
            k_eff = LEN_W'(MAX_KMER);
        end
        m_eff = r_m_cfg;
        if (r_m_cfg == '0) begin
            m_eff = 6'd1;
        end else if (r_m_cfg > k_eff) begin
            m_eff = k_eff;
        end
    end

    assign full_life = k_eff - m_eff + 6'd1;
    assign mm        = base_mask(m_eff);

    // window and rescan row
    generate
        for (genvar i = 0; i < MAX_KMER; i++) begin : g_cell
            logic [1:0] win_in;
            logic [1:0] load_in;
            logic [1:0] scan_in;

            if (i == 0) begin : g_first
                assign win_in = i_base;
            end else begin : g_rest
                assign win_in = i_restart ? 2'b00 : c_base[i-1];
            end

            if (i == MAX_KMER - 1) begin : g_top
                assign load_in = 2'b00;
                assign scan_in = 2'b00;
            end else begin : g_mid
                assign load_in = c_next[i+1];
                assign scan_in = c_scan[i+1];
            end

            kmm_cell u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (cell_ctl),
                .i_keep         (LEN_W'(i) < k_eff),
                .i_win_in       (win_in),
                .i_scan_load_in (load_in),
                .i_scan_in      (scan_in),
                .o_base         (c_base[i]),
                .o_base_next    (c_next[i]),
                .o_scan         (c_scan[i])
            );

            assign next_flat[2*i +: 2] = c_next[i];
            assign scan_flat[2*i +: 2] = c_scan[i];
        end
    endgenerate

    kmm_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (trk_ctl),
        .i_newest    (newest),
        .i_full_life (full_life),
        .i_cand      (MIN_W'(scan_flat) & mm),
        .o_best      (trk_best),
        .o_best_pos  (trk_best_pos),
        .o_pos       (trk_pos)
    );

    // handshake
    assign o_stall     = (r_state != S_IDLE) || r_pend;
    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_ov || !i_stall;
    assign o_cfg_ready = 1'b1;

    // step of one item
    always_comb begin
        min_base  = i_restart ? '0 : r_min;
        life_base = i_restart ? 6'd1 : r_life;
        fill_base = i_restart ? '0 : r_fill;
        n_fill    = (fill_base < k_eff) ? fill_base + 6'd1 : fill_base;
        newest    = MIN_W'(next_flat) & mm;
        take_new  = newest <= min_base;
        go_scan   = !take_new && !(life_base > 6'd1);
    end

    assign scan_done = (r_state == S_SCAN) && (trk_pos <= 6'd1);

    assign cell_ctl.shift      = accept;
    assign cell_ctl.scan_load  = accept && go_scan;
    assign cell_ctl.scan_shift = (r_state == S_SCAN) && !scan_done;
    assign trk_ctl.load        = accept && go_scan;
    assign trk_ctl.step        = (r_state == S_SCAN) && !scan_done;

    always_comb begin
        fin      = (accept && !go_scan) || scan_done;
        fin_min  = trk_best;
        fin_life = trk_best_pos;
        fin_full = r_fill >= k_eff;
        if (accept) begin
            fin_full = n_fill >= k_eff;
            if (take_new) begin
                fin_min  = newest;
                fin_life = full_life;
            end else begin
                fin_min  = min_base;
                fin_life = life_base - 6'd1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && go_scan) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k_cfg <= KMER_RST;
            r_m_cfg <= MLEN_RST;
            r_min   <= '0;
            r_life  <= 6'd1;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_KMER_SIZE: r_k_cfg <= i_cfg_data;
                    REG_MIN_LEN:   r_m_cfg <= i_cfg_data;
                endcase
            end
            if (accept) begin
                r_fill <= n_fill;
            end
            if (fin) begin
                r_min  <= fin_min;
                r_life <= fin_life;
            end
            if (fin && !out_free) begin
                r_pend <= 1'b1;
            end else if (r_pend && out_free) begin
                r_pend <= 1'b0;
            end
            r_ov <= (out_free && (fin || r_pend)) || (r_ov && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && fin) begin
            r_omin  <= fin_min;
            r_olife <= fin_life;
            r_ofull <= fin_full;
        end else if (out_free && r_pend) begin
            r_omin  <= r_min;
            r_olife <= r_life;
            r_ofull <= r_fill >= k_eff;
        end
    end

    assign o_valid       = r_ov;
    assign o_minimizer   = r_omin;
    assign o_life_left   = r_olife;
    assign o_window_full = r_ofull;

    a_life_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_life_left != '0) && (o_life_left <= LEN_W'(MAX_KMER)))
        else $error("life out of range");

    a_item_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN) || o_valid || r_pend)
        else $error("accepted item lost");

    a_scan_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (trk_pos != '0) && (trk_pos <= LEN_W'(MAX_KMER)))
        else $error("rescan position out of range");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |=> (r_state == S_IDLE) && (o_valid || r_pend))
        else $error("rescan did not deliver");

endmodule

// ===== rtl/kmm_cell.sv =====
// ----------------------------------------------------------------------------
// kmm_cell
// One base of the k-mer window plus one base of the rescan row.
// ----------------------------------------------------------------------------
module kmm_cell
    import kmm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_keep,
    input  logic [1:0] i_win_in,
    input  logic [1:0] i_scan_load_in,
    input  logic [1:0] i_scan_in,
    output logic [1:0] o_base,
    output logic [1:0] o_base_next,
    output logic [1:0] o_scan
);

    logic [1:0] r_base;
    logic [1:0] n_base;
    logic [1:0] r_scan;

    always_comb begin
        n_base = r_base;
        if (i_ctl.shift) begin
            n_base = i_keep ? i_win_in : 2'b00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 2'b00;
        end else begin
            r_base <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_load) begin
            r_scan <= i_scan_load_in;
        end else if (i_ctl.scan_shift) begin
            r_scan <= i_scan_in;
        end
    end

    assign o_base      = r_base;
    assign o_base_next = n_base;
    assign o_scan      = r_scan;

endmodule

// ===== rtl/kmm_track.sv =====
// ----------------------------------------------------------------------------
// kmm_track
// Running minimum of the rescan, one candidate m-mer per cycle.
// ----------------------------------------------------------------------------
module kmm_track
    import kmm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_trk_ctl         i_ctl,
    input  logic [MIN_W-1:0] i_newest,
    input  logic [LEN_W-1:0] i_full_life,
    input  logic [MIN_W-1:0] i_cand,
    output logic [MIN_W-1:0] o_best,
    output logic [LEN_W-1:0] o_best_pos,
    output logic [LEN_W-1:0] o_pos
);

    logic [MIN_W-1:0] r_best;
    logic [LEN_W-1:0] r_best_pos;
    logic [LEN_W-1:0] r_pos;
    logic [LEN_W-1:0] pos_dec;

    assign pos_dec = r_pos - 6'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_ctl.load) begin
            r_pos <= i_full_life;
        end else if (i_ctl.step) begin
            r_pos <= pos_dec;
        end
    end

    // ties go to the older window
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_best     <= i_newest;
            r_best_pos <= i_full_life;
        end else if (i_ctl.step && (i_cand <= r_best)) begin
            r_best     <= i_cand;
            r_best_pos <= pos_dec;
        end
    end

    assign o_best     = r_best;
    assign o_best_pos = r_best_pos;
    assign o_pos      = r_pos;

endmodule
